// ===== rtl/core/sbt_pkg.sv =====
// Shared types, constants and character classes for the source byte tokenizer.
package sbt_pkg;

  // Width of the position, line and column counters (wrap at this width)
  localparam int POS_BITS = 32;
  typedef logic [POS_BITS-1:0] pos_t;

  // Width of the offsets and counts carried on each result item
  localparam int OUT_BITS = 32;
  typedef logic [OUT_BITS-1:0] out_word_t;

  // Token kinds
  localparam logic [4:0] KIND_SYMBOL    = 5'd0;
  localparam logic [4:0] KIND_NUMBER    = 5'd1;
  localparam logic [4:0] KIND_STRING    = 5'd2;
  localparam logic [4:0] KIND_DIRECTIVE = 5'd3;
  localparam logic [4:0] KIND_LPAREN    = 5'd4;
  localparam logic [4:0] KIND_RPAREN    = 5'd5;
  localparam logic [4:0] KIND_COMMA     = 5'd6;
  localparam logic [4:0] KIND_STAR      = 5'd7;
  localparam logic [4:0] KIND_LBRACE    = 5'd8;
  localparam logic [4:0] KIND_RBRACE    = 5'd9;
  localparam logic [4:0] KIND_LBRACKET  = 5'd10;
  localparam logic [4:0] KIND_RBRACKET  = 5'd11;
  localparam logic [4:0] KIND_LESS      = 5'd12;
  localparam logic [4:0] KIND_GREATER   = 5'd13;
  localparam logic [4:0] KIND_SEMI      = 5'd14;
  localparam logic [4:0] KIND_PLUS      = 5'd15;
  localparam logic [4:0] KIND_MINUS     = 5'd16;
  localparam logic [4:0] KIND_SLASH     = 5'd17;
  localparam logic [4:0] KIND_BACKSLASH = 5'd18;
  localparam logic [4:0] KIND_DOT       = 5'd19;
  localparam logic [4:0] KIND_QUOTE     = 5'd20;
  localparam logic [4:0] KIND_AT        = 5'd21;
  localparam logic [4:0] KIND_COLON     = 5'd22;
  localparam logic [4:0] KIND_EQUALS    = 5'd23;
  localparam logic [4:0] KIND_INVALID   = 5'd24;

  // Characters with a special role
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_VTAB       = 8'h0B;
  localparam logic [7:0] CH_FORMFEED   = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result item
  typedef struct packed {
    logic [4:0] kind;
    out_word_t  start_offset;
    out_word_t  end_offset;
    out_word_t  line_number;
    out_word_t  column_number;
    logic       unterminated;
    logic       last_of_run;
  } token_t;

  // All results caused by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } scan_res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_FORMFEED ||
           c == CH_CR || c == CH_VTAB;
  endfunction

  // Map a single punctuation byte to its kind, anything else is invalid
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2C:   k = KIND_COMMA;
      8'h2A:   k = KIND_STAR;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h3C:   k = KIND_LESS;
      8'h3E:   k = KIND_GREATER;
      8'h3B:   k = KIND_SEMI;
      8'h2B:   k = KIND_PLUS;
      8'h2D:   k = KIND_MINUS;
      8'h2F:   k = KIND_SLASH;
      8'h5C:   k = KIND_BACKSLASH;
      8'h2E:   k = KIND_DOT;
      8'h27:   k = KIND_QUOTE;
      8'h40:   k = KIND_AT;
      8'h3A:   k = KIND_COLON;
      8'h3D:   k = KIND_EQUALS;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Build a result item from counter values, keeping the low output bits
  function automatic token_t make_token(input logic [4:0] kind, input pos_t start,
                                        input pos_t stop, input pos_t line,
                                        input pos_t col, input logic unterm);
    token_t t;
    t.kind          = kind;
    t.start_offset  = OUT_BITS'(start);
    t.end_offset    = OUT_BITS'(stop);
    t.line_number   = OUT_BITS'(line);
    t.column_number = OUT_BITS'(col);
    t.unterminated  = unterm;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

endpackage

// ===== rtl/core/source_byte_tokenizer_core.sv =====
// Byte-serial lexical scanner: input register, scan step and result queue.
// An accepted byte waits in the input register until the four-entry result queue
// has room for two items; its tokens then go into the queue, whose head is m_tdata.
// Throughput: one byte per cycle while the sink takes one item per cycle; a byte
// that causes two tokens writes both at once, and the one-item port drains them.
// Reset (rst, synchronous): scan state and counters to zero, queue empty.
module source_byte_tokenizer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] byte_value
  input  logic         s_tlast,   // end_of_input
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // token_kind, start_offset, end_offset,
                                  // line_number, column_number, zero fill
  output logic         m_tuser,   // unterminated
  output logic         m_tlast    // last_of_run
);
  import sbt_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       advance;
  logic       room2;
  scan_res_t  res;
  token_t     out_tok;

  assign advance  = in_valid && room2;
  assign s_tready = !in_valid || advance;

  // Hold the accepted byte for one scan step
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  sbt_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .byte_value   (in_byte),
    .end_of_input (in_eoi),
    .res          (res)
  );

  sbt_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (res),
    .wr_en     (advance),
    .room2     (room2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok)
  );

  // Pack the head item onto the stream
  assign m_tdata = {3'b000, out_tok.column_number, out_tok.line_number,
                    out_tok.end_offset, out_tok.start_offset, out_tok.kind};
  assign m_tuser = out_tok.unterminated;
  assign m_tlast = out_tok.last_of_run;

endmodule

// ===== rtl/core/sbt_scan.sv =====
// Scanner state and the single-pass step logic for one source byte.
module sbt_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_value,
  input  logic             end_of_input,
  output sbt_pkg::scan_res_t res
);
  import sbt_pkg::*;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_SYMBOL,
    MODE_NUMBER,
    MODE_STRING,
    MODE_DIRECTIVE
  } mode_t;

  mode_t      mode, mode_next;
  pos_t       byte_pos, line_cnt, col_cnt;
  pos_t       open_start, open_line, open_col;
  logic [4:0] open_kind;

  pos_t       open_start_next, open_line_next, open_col_next;
  logic [4:0] open_kind_next;
  pos_t       next_pos;
  logic       rescan, close_hit, punct_hit, eoi_hit;
  pos_t       close_end;
  token_t     close_tok, punct_tok, eoi_tok;
  logic [1:0] n;

  // Work out the mode transition and the tokens this byte closes or opens
  always_comb begin
    next_pos        = byte_pos + pos_t'(1);
    mode_next       = mode;
    open_kind_next  = open_kind;
    open_start_next = open_start;
    open_line_next  = open_line;
    open_col_next   = open_col;
    rescan          = 1'b0;
    close_hit       = 1'b0;
    close_end       = byte_pos;
    punct_hit       = 1'b0;

    unique case (mode)
      MODE_SYMBOL: begin
        if (!(is_alpha(byte_value) || is_digit(byte_value) ||
              byte_value == CH_UNDERSCORE)) begin
          close_hit = 1'b1;
          mode_next = MODE_START;
          rescan    = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!is_digit(byte_value)) begin
          close_hit = 1'b1;
          mode_next = MODE_START;
          rescan    = 1'b1;
        end
      end
      MODE_STRING: begin
        if (byte_value == CH_DQUOTE) begin
          close_hit = 1'b1;
          close_end = next_pos;
          mode_next = MODE_START;
        end
      end
      MODE_DIRECTIVE: begin
        if (byte_value == CH_NEWLINE) begin
          close_hit = 1'b1;
          mode_next = MODE_START;
        end
      end
      default: begin
        mode_next = MODE_START;
        rescan    = 1'b1;
      end
    endcase

    // Scan the byte again in the start mode
    if (rescan && !is_space(byte_value)) begin
      if (is_alpha(byte_value) || is_digit(byte_value) || byte_value == CH_HASH ||
          byte_value == CH_DQUOTE) begin
        open_start_next = byte_pos;
        open_line_next  = line_cnt;
        open_col_next   = col_cnt;
        if (is_alpha(byte_value)) begin
          mode_next      = MODE_SYMBOL;
          open_kind_next = KIND_SYMBOL;
        end else if (is_digit(byte_value)) begin
          mode_next      = MODE_NUMBER;
          open_kind_next = KIND_NUMBER;
        end else if (byte_value == CH_HASH) begin
          mode_next      = MODE_DIRECTIVE;
          open_kind_next = KIND_DIRECTIVE;
        end else begin
          mode_next      = MODE_STRING;
          open_kind_next = KIND_STRING;
        end
      end else begin
        punct_hit = 1'b1;
      end
    end

    eoi_hit = end_of_input && (mode_next != MODE_START);

    close_tok = make_token(open_kind, open_start, close_end, open_line, open_col, 1'b0);
    punct_tok = make_token(punct_kind(byte_value), byte_pos, next_pos, line_cnt,
                           col_cnt, 1'b0);
    eoi_tok   = make_token(open_kind_next, open_start_next, next_pos, open_line_next,
                           open_col_next, 1'b1);

    // Place the tokens in order; at most two can arise from one byte
    n = 2'(close_hit) + 2'(punct_hit) + 2'(eoi_hit);
    res.count = n;
    if (close_hit) begin
      res.tok0 = close_tok;
      res.tok1 = punct_hit ? punct_tok : eoi_tok;
    end else if (punct_hit) begin
      res.tok0 = punct_tok;
      res.tok1 = eoi_tok;
    end else begin
      res.tok0 = eoi_tok;
      res.tok1 = eoi_tok;
    end
    res.tok0.last_of_run = (n == 2'd1);
    res.tok1.last_of_run = 1'b1;
  end

  // Advance the counters and scan state; end of input starts a fresh buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_START;
      byte_pos   <= '0;
      line_cnt   <= '0;
      col_cnt    <= '0;
      open_kind  <= '0;
      open_start <= '0;
      open_line  <= '0;
      open_col   <= '0;
    end else if (step) begin
      if (end_of_input) begin
        mode       <= MODE_START;
        byte_pos   <= '0;
        line_cnt   <= '0;
        col_cnt    <= '0;
        open_kind  <= '0;
        open_start <= '0;
        open_line  <= '0;
        open_col   <= '0;
      end else begin
        mode       <= mode_next;
        byte_pos   <= next_pos;
        open_kind  <= open_kind_next;
        open_start <= open_start_next;
        open_line  <= open_line_next;
        open_col   <= open_col_next;
        if (byte_value == CH_NEWLINE) begin
          line_cnt <= line_cnt + pos_t'(1);
          col_cnt  <= '0;
        end else begin
          col_cnt  <= col_cnt + pos_t'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/sbt_token_fifo.sv =====
// Small result queue that takes up to two items per cycle and gives out one.
module sbt_token_fifo (
  input  logic              clk,
  input  logic              rst,
  input  sbt_pkg::scan_res_t wr,
  input  logic              wr_en,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output sbt_pkg::token_t   out_tok
);
  import sbt_pkg::*;

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [1:0]         n_wr;
  logic               pop;

  assign n_wr      = wr_en ? wr.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_tok   = mem[rd_ptr];
  assign room2     = (count <= FIFO_CW'(FIFO_DEPTH - 2));

  // Store the new items
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      mem[wr_ptr] <= wr.tok0;
    end
    if (n_wr == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= wr.tok1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(n_wr);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(n_wr) - FIFO_CW'(pop);
    end
  end

endmodule
